// File: rtl/core/hsc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hsc_pkg: shared types and constants of the Hamming SEC codec
// Word layout constants, derived length configuration and parity masks.
// ----------------------------------------------------------------------------
package hsc_pkg;

  localparam int unsigned WORD_W            = 63;  // codeword / data port width
  localparam int unsigned DATA_W            = 57;  // data slots in a full codeword
  localparam int unsigned PAR_W             = 6;   // parity / syndrome bits
  localparam int unsigned LEN_W             = 6;   // width of k and n
  localparam int unsigned MAX_DATA_BITS_DEF = 57;
  localparam logic [LEN_W-1:0] DATA_BITS_RST = LEN_W'(4);

  localparam logic MODE_ENCODE = 1'b0;
  localparam logic MODE_DECODE = 1'b1;

  typedef logic [LEN_W-1:0] pos_arr_t [DATA_W];

  // Derived length setup, held in registers while the block runs.
  typedef struct packed {
    logic [LEN_W-1:0]  k;
    logic [LEN_W-1:0]  n;
    logic [DATA_W-1:0] kmask;
    logic [WORD_W-1:0] nmask;
  } cfg_t;

  // One codec result.
  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic [PAR_W-1:0]  syndrome;
    logic              corrected;
    logic              uncorrectable;
  } res_t;

  // Codeword index of each data bit: every index whose 1-based position is
  // not a power of two, in rising order.
  function automatic pos_arr_t data_positions();
    pos_arr_t    pos;
    int unsigned j;
    j = 0;
    for (int unsigned d = 0; d < DATA_W; d++) begin
      pos[d] = '0;
    end
    for (int unsigned i = 0; i < WORD_W; i++) begin
      if (((i & (i + 1)) != 0) && (j < DATA_W)) begin
        pos[j] = LEN_W'(i);
        j++;
      end
    end
    return pos;
  endfunction

  localparam pos_arr_t DATA_POS = data_positions();

  // Indices covered by check p: those whose 1-based position has bit p set.
  function automatic logic [WORD_W-1:0] par_mask(int unsigned p);
    logic [WORD_W-1:0] m;
    for (int unsigned i = 0; i < WORD_W; i++) begin
      m[i] = (((i + 1) >> p) & 1) != 0;
    end
    return m;
  endfunction

  // Clamp the requested length, find the parity count and build the masks.
  function automatic cfg_t derive_cfg(logic [LEN_W-1:0] raw, int unsigned max_k);
    cfg_t        c;
    int unsigned kk;
    int unsigned r;
    int unsigned nn;
    kk = raw;
    if (kk < 1) kk = 1;
    if (kk > max_k) kk = max_k;
    r = PAR_W;
    for (int unsigned t = PAR_W; t > 0; t--) begin
      if ((1 << (t - 1)) >= (kk + (t - 1) + 1)) r = t - 1;
    end
    nn = kk + r;
    c.k = LEN_W'(kk);
    c.n = LEN_W'(nn);
    for (int unsigned i = 0; i < DATA_W; i++) begin
      c.kmask[i] = i < kk;
    end
    for (int unsigned i = 0; i < WORD_W; i++) begin
      c.nmask[i] = i < nn;
    end
    return c;
  endfunction

endpackage : hsc_pkg
`default_nettype wire

// File: rtl/core/hamming_sec_codec_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hamming_sec_codec_unit: shortened Hamming single-error-correcting codec
// Encodes data words or decodes and corrects codewords, one word per cycle.
// ----------------------------------------------------------------------------
// Usage: the block takes one word in every cycle; busy is always low, so a
// word is taken whenever start is high. Each word yields exactly one result,
// shown for one cycle with out_valid high once it has passed the input register,
// one pass of parity XOR trees and the result register. The
// receiver cannot stall, so capture every out_valid cycle. The data length
// k comes from cfg_data_bits (0 reads as 1, values above MAX_DATA_BITS are
// clamped); write it only while no word is in flight. In decode mode a
// nonzero syndrome up to the code length flips that bit and raises
// out_corrected; a larger syndrome raises out_uncorrectable and leaves the
// word untouched.
module hamming_sec_codec_unit #(
  parameter int unsigned MAX_DATA_BITS = hsc_pkg::MAX_DATA_BITS_DEF
) (
  input  wire                          clk,
  input  wire                          rst_n,
  // word input
  input  wire                          start,
  output logic                         busy,
  input  wire                          in_mode,
  input  wire  [hsc_pkg::WORD_W-1:0]   in_word_in,
  // result output
  output logic                         out_valid,
  output logic [hsc_pkg::WORD_W-1:0]   out_word_out,
  output logic [hsc_pkg::PAR_W-1:0]    out_syndrome,
  output logic                         out_corrected,
  output logic                         out_uncorrectable,
  // length configuration
  input  wire                          cfg_valid,
  output logic                         cfg_ready,
  input  wire  [hsc_pkg::LEN_W-1:0]    cfg_data_bits
);
  import hsc_pkg::*;

  cfg_t              cfg;
  logic              in_valid_r;
  logic              in_mode_r;
  logic [WORD_W-1:0] in_word_r;
  res_t              res;
  logic              res_valid_r;
  logic              res_mode_r;
  res_t              res_r;

  // Every cycle is open for a new word; both stages advance unconditionally.
  assign busy = 1'b0;

  hsc_cfg #(
    .MAX_DATA_BITS (MAX_DATA_BITS)
  ) u_cfg (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data_bits (cfg_data_bits),
    .cfg           (cfg)
  );

  // Input stage: capture the word on start, drop the valid otherwise.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      in_mode_r <= in_mode;
      in_word_r <= in_word_in;
    end
  end

  hsc_core u_core (
    .mode (in_mode_r),
    .word (in_word_r),
    .cfg  (cfg),
    .res  (res)
  );

  // Result stage: hold the result for exactly one cycle as the strobe.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
    end else begin
      res_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid_r) begin
      res_r      <= res;
      res_mode_r <= in_mode_r;
    end
  end

  assign out_valid         = res_valid_r;
  assign out_word_out      = res_r.word;
  assign out_syndrome      = res_r.syndrome;
  assign out_corrected     = res_r.corrected;
  assign out_uncorrectable = res_r.uncorrectable;

  // A taken word shows up as a result after the input and result registers.
  a_latency : assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> ##1 out_valid)
    else $error("result strobe missing two cycles after start");

  // Correction and failure flags are exclusive and tied to a nonzero syndrome.
  a_flags : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_corrected && out_uncorrectable)
                  && ((out_corrected || out_uncorrectable) == (out_syndrome != '0)))
    else $error("decode flags disagree with syndrome");

  // Uncorrectable only when the syndrome points past the code length.
  a_bad_range : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_uncorrectable) |-> ({1'b0, out_syndrome} > {1'b0, cfg.n}))
    else $error("uncorrectable flagged inside code length");

  // Encoded words have no bits at or above the code length and no syndrome.
  a_enc_clean : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (res_mode_r == MODE_ENCODE))
      |-> ((out_word_out & ~cfg.nmask) == '0) && (out_syndrome == '0))
    else $error("encode result spills past code length");

endmodule : hamming_sec_codec_unit
`default_nettype wire

// File: rtl/core/hsc_cfg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hsc_cfg: length configuration register
// Holds the clamped data length, code length and the masks derived from them.
// ----------------------------------------------------------------------------
module hsc_cfg #(
  parameter int unsigned MAX_DATA_BITS = hsc_pkg::MAX_DATA_BITS_DEF
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          cfg_valid,
  output logic                         cfg_ready,
  input  wire  [hsc_pkg::LEN_W-1:0]    cfg_data_bits,
  output hsc_pkg::cfg_t                cfg
);
  import hsc_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      cfg_nxt = derive_cfg(cfg_data_bits, MAX_DATA_BITS);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= derive_cfg(DATA_BITS_RST, MAX_DATA_BITS);
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule : hsc_cfg
`default_nettype wire

// File: rtl/core/hsc_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hsc_core: single-pass Hamming encode / decode logic
// Scatter and parity XOR trees for encode; syndrome, flip and gather for decode.
// ----------------------------------------------------------------------------
module hsc_core (
  input  wire                          mode,
  input  wire  [hsc_pkg::WORD_W-1:0]   word,
  input  hsc_pkg::cfg_t                cfg,
  output hsc_pkg::res_t                res
);
  import hsc_pkg::*;

  logic [DATA_W-1:0] enc_data;
  logic [WORD_W-1:0] enc_code;
  logic [PAR_W-1:0]  enc_par;
  logic [WORD_W-1:0] dec_word;
  logic [PAR_W-1:0]  dec_syn;
  logic              dec_fix;
  logic              dec_bad;
  logic [WORD_W-1:0] dec_flip;
  logic [WORD_W-1:0] dec_fixed;
  logic [DATA_W-1:0] dec_data;

  // Encode: drop data bits at or above k, scatter, then fill parity slots.
  always_comb begin
    enc_data = word[DATA_W-1:0] & cfg.kmask;
    enc_code = '0;
    for (int unsigned j = 0; j < DATA_W; j++) begin
      enc_code[DATA_POS[j]] = enc_data[j];
    end
    for (int unsigned p = 0; p < PAR_W; p++) begin
      enc_par[p] = ^(enc_code & par_mask(p));
    end
    for (int unsigned p = 0; p < PAR_W; p++) begin
      enc_code[(1 << p) - 1] = enc_par[p];
    end
  end

  // Decode: checks beyond the parity count see no covered bits and read 0.
  always_comb begin
    dec_word = word & cfg.nmask;
    for (int unsigned p = 0; p < PAR_W; p++) begin
      dec_syn[p] = ^(dec_word & par_mask(p));
    end
    dec_fix  = (dec_syn != '0) && ({1'b0, dec_syn} <= {1'b0, cfg.n});
    dec_bad  = (dec_syn != '0) && !dec_fix;
    dec_flip = dec_fix ? (WORD_W'(1) << (dec_syn - PAR_W'(1))) : '0;
    dec_fixed = dec_word ^ dec_flip;
    for (int unsigned j = 0; j < DATA_W; j++) begin
      dec_data[j] = dec_fixed[DATA_POS[j]];
    end
  end

  always_comb begin
    if (mode == MODE_DECODE) begin
      res.word          = WORD_W'(dec_data & cfg.kmask);
      res.syndrome      = dec_syn;
      res.corrected     = dec_fix;
      res.uncorrectable = dec_bad;
    end else begin
      res.word          = enc_code & cfg.nmask;
      res.syndrome      = '0;
      res.corrected     = 1'b0;
      res.uncorrectable = 1'b0;
    end
  end

endmodule : hsc_core
`default_nettype wire
